// ===== rtl/udpdmx_pkg.sv =====
// Package with shared types, constants and control structs for the UDP port demultiplexer.
`default_nettype none
package udpdmx_pkg;
    localparam int PORT_SLOTS = 64;
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W = $clog2(PORT_SLOTS);
    localparam int CNT_W = $clog2(PORT_SLOTS + 1);
    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DESC_W = 61;
    localparam int STORE_DEPTH = PORT_SLOTS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam logic [1:0] OP_BIND = 2'd0;
    localparam logic [1:0] OP_DELIVER = 2'd1;
    localparam logic [1:0] OP_RECEIVE = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ALREADY = 3'd1;
    localparam logic [2:0] ST_FULL_TABLE = 3'd2;
    localparam logic [2:0] ST_NOT_BOUND = 3'd3;
    localparam logic [2:0] ST_MALFORMED = 3'd4;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd5;
    localparam logic [2:0] ST_EMPTY = 3'd6;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_DECIDE,
        S_READ_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic do_bind;
        logic do_enqueue;
        logic do_dequeue;
        logic finish;
        logic [2:0] status;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] op;
        logic hdr_ok;
        logic scan_done;
        logic found;
        logic table_full;
        logic queue_full;
        logic queue_empty;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/udpdmx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module udpdmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input wire logic clk,
    input wire logic wr_en,
    input wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input wire logic [WIDTH-1:0] wr_data,
    input wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/udpdmx_ctrl.sv =====
// Controller state machine sequencing the port scan, queue update and result.
`default_nettype none
module udpdmx_ctrl (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input wire logic out_ready,
    input wire udpdmx_pkg::stat_t stat,
    output udpdmx_pkg::ctrl_t ctrl
);
    import udpdmx_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan_start = 1'b1;
                state_next = S_SCAN_WAIT;
            end
            S_SCAN_WAIT:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ctrl.scan_step = 1'b1;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                ctrl.finish = 1'b1;
                case (stat.op)
                    OP_BIND:
                    begin
                        if (stat.found)
                        begin
                            ctrl.status = ST_ALREADY;
                        end
                        else if (stat.table_full)
                        begin
                            ctrl.status = ST_FULL_TABLE;
                        end
                        else
                        begin
                            ctrl.status = ST_OK;
                            ctrl.do_bind = 1'b1;
                        end
                    end
                    OP_DELIVER:
                    begin
                        if (!stat.hdr_ok)
                        begin
                            ctrl.status = ST_MALFORMED;
                        end
                        else if (!stat.found)
                        begin
                            ctrl.status = ST_NOT_BOUND;
                        end
                        else if (stat.queue_full)
                        begin
                            ctrl.status = ST_QUEUE_FULL;
                        end
                        else
                        begin
                            ctrl.status = ST_OK;
                            ctrl.do_enqueue = 1'b1;
                        end
                    end
                    OP_RECEIVE:
                    begin
                        if (!stat.found)
                        begin
                            ctrl.status = ST_NOT_BOUND;
                        end
                        else if (stat.queue_empty)
                        begin
                            ctrl.status = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.status = ST_OK;
                            ctrl.do_dequeue = 1'b1;
                            ctrl.finish = 1'b0;
                            state_next = S_READ_WAIT;
                        end
                    end
                    default:
                    begin
                        ctrl.status = ST_MALFORMED;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                ctrl.finish = 1'b1;
                ctrl.status = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result is pending");
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.do_bind, ctrl.do_enqueue, ctrl.do_dequeue}))
        else $error("more than one table action at once");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> out_valid)
        else $error("result not presented after finish");
endmodule
`default_nettype wire

// ===== rtl/udpdmx_dp.sv =====
// Datapath with the port table, per-slot queue pointers and descriptor store.
`default_nettype none
module udpdmx_dp (
    input wire logic clk,
    input wire logic rst_n,
    input wire udpdmx_pkg::ctrl_t ctrl,
    output udpdmx_pkg::stat_t stat,
    input wire logic [1:0] op,
    input wire logic [15:0] port,
    input wire logic [15:0] ethertype,
    input wire logic [12:0] frame_len,
    input wire logic [15:0] udp_length,
    input wire logic [31:0] source_ip,
    input wire logic [15:0] source_port,
    input wire logic [12:0] max_len,
    output logic [2:0] status,
    output logic [31:0] out_source_ip,
    output logic [15:0] out_source_port,
    output logic [12:0] out_length
);
    import udpdmx_pkg::*;

    logic [1:0] op_reg;
    logic [15:0] port_reg;
    logic hdr_ok_reg;
    logic [31:0] sip_reg;
    logic [15:0] sport_reg;
    logic [12:0] plen_reg;
    logic [12:0] maxl_reg;
    logic [CNT_W-1:0] bound_count_reg;
    logic [CNT_W-1:0] scan_reg;
    logic found_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic scan_busy_reg;
    logic [15:0] tbl_rd;
    logic [DESC_W-1:0] desc_rd;
    logic [2:0] status_reg;
    logic [31:0] oip_reg;
    logic [15:0] oport_reg;
    logic [12:0] olen_reg;
    logic rd_pend_reg;
    logic [SLOT_W-1:0] tbl_raddr;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [QIDX_W-1:0] tail;
    logic hdr_ok;
    logic [16:0] need_len;
    logic [QIDX_W+FILL_W-1:0] qptr_rd;
    logic [QIDX_W+FILL_W-1:0] qptr_wdata;
    logic [SLOT_W-1:0] qptr_waddr;
    logic qptr_we;
    logic [QIDX_W-1:0] q_head;
    logic [FILL_W-1:0] q_fill;

    assign need_len = {1'b0, udp_length} + 17'd34;
    assign hdr_ok = (ethertype == ETYPE_IPV4) && (frame_len >= 13'd42)
        && (udp_length >= 16'd8) && ({4'd0, frame_len} >= need_len);

    assign q_head = qptr_rd[QIDX_W+FILL_W-1:FILL_W];
    assign q_fill = qptr_rd[FILL_W-1:0];

    assign tbl_raddr = scan_reg[SLOT_W-1:0];
    assign tail = QIDX_W'((q_head + QIDX_W'(q_fill)) % QUEUE_DEPTH);
    assign st_waddr = {slot_reg, QIDX_W'(0)} >> (QIDX_W - $clog2(QUEUE_DEPTH)) | ADDR_W'(tail);
    assign st_raddr = {slot_reg, QIDX_W'(0)} >> (QIDX_W - $clog2(QUEUE_DEPTH))
        | ADDR_W'(q_head);

    assign qptr_we = ctrl.do_bind || ctrl.do_enqueue || ctrl.do_dequeue;
    assign qptr_waddr = ctrl.do_bind ? bound_count_reg[SLOT_W-1:0] : slot_reg;

    always_comb
    begin
        qptr_wdata = '0;
        if (ctrl.do_enqueue)
        begin
            qptr_wdata = {q_head, q_fill + FILL_W'(1)};
        end
        else if (ctrl.do_dequeue)
        begin
            qptr_wdata = {QIDX_W'((q_head + QIDX_W'(1)) % QUEUE_DEPTH), q_fill - FILL_W'(1)};
        end
    end

    udpdmx_ram #(.WIDTH(16), .DEPTH(PORT_SLOTS)) u_tbl (
        .clk(clk),
        .wr_en(ctrl.do_bind),
        .wr_addr(bound_count_reg[SLOT_W-1:0]),
        .wr_data(port_reg),
        .rd_addr(tbl_raddr),
        .rd_data(tbl_rd)
    );

    udpdmx_ram #(.WIDTH(QIDX_W + FILL_W), .DEPTH(PORT_SLOTS)) u_qptr (
        .clk(clk),
        .wr_en(qptr_we),
        .wr_addr(qptr_waddr),
        .wr_data(qptr_wdata),
        .rd_addr(slot_reg),
        .rd_data(qptr_rd)
    );

    udpdmx_ram #(.WIDTH(DESC_W), .DEPTH(STORE_DEPTH)) u_store (
        .clk(clk),
        .wr_en(ctrl.do_enqueue),
        .wr_addr(st_waddr),
        .wr_data({sip_reg, sport_reg, plen_reg}),
        .rd_addr(st_raddr),
        .rd_data(desc_rd)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg <= op;
            port_reg <= port;
            hdr_ok_reg <= hdr_ok;
            sip_reg <= source_ip;
            sport_reg <= source_port;
            plen_reg <= 13'(udp_length - 16'd8);
            maxl_reg <= max_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_count_reg <= '0;
            scan_reg <= '0;
            found_reg <= 1'b0;
            slot_reg <= '0;
            scan_busy_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            status_reg <= ST_OK;
            oip_reg <= '0;
            oport_reg <= '0;
            olen_reg <= '0;
        end
        else
        begin
            if (ctrl.scan_start)
            begin
                scan_reg <= '0;
                found_reg <= 1'b0;
                scan_busy_reg <= 1'b0;
            end
            if (ctrl.scan_step)
            begin
                if (scan_busy_reg && tbl_rd == port_reg)
                begin
                    found_reg <= 1'b1;
                    slot_reg <= SLOT_W'(scan_reg - CNT_W'(1));
                end
                else
                begin
                    scan_busy_reg <= 1'b1;
                    scan_reg <= scan_reg + CNT_W'(1);
                end
            end
            if (ctrl.do_bind)
            begin
                bound_count_reg <= bound_count_reg + CNT_W'(1);
            end
            rd_pend_reg <= ctrl.do_dequeue;
            if (ctrl.finish)
            begin
                status_reg <= ctrl.status;
                if (rd_pend_reg)
                begin
                    oip_reg <= desc_rd[60:29];
                    oport_reg <= desc_rd[28:13];
                    olen_reg <= (desc_rd[12:0] > maxl_reg) ? maxl_reg : desc_rd[12:0];
                end
                else
                begin
                    oip_reg <= '0;
                    oport_reg <= '0;
                    olen_reg <= '0;
                end
            end
        end
    end

    assign stat.op = op_reg;
    assign stat.hdr_ok = hdr_ok_reg;
    assign stat.scan_done = found_reg
        || (scan_busy_reg && scan_reg == bound_count_reg && tbl_rd != port_reg)
        || (!scan_busy_reg && bound_count_reg == '0);
    assign stat.found = found_reg;
    assign stat.table_full = (bound_count_reg >= CNT_W'(PORT_SLOTS));
    assign stat.queue_full = (q_fill >= FILL_W'(QUEUE_DEPTH));
    assign stat.queue_empty = (q_fill == '0);

    assign status = status_reg;
    assign out_source_ip = oip_reg;
    assign out_source_port = oport_reg;
    assign out_length = olen_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bound_count_reg <= CNT_W'(PORT_SLOTS))
        else $error("bound count beyond table size");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_enqueue |-> q_fill < FILL_W'(QUEUE_DEPTH))
        else $error("enqueue into full queue");
    a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_dequeue |-> q_fill != '0)
        else $error("dequeue from empty queue");
endmodule
`default_nettype wire

// ===== rtl/udp_port_demux_queue.sv =====
// Top level of the UDP port demultiplexer with per-port descriptor queues.
// Input channel: in_valid/in_ready carry one word of op, port, header fields
// and max_len. Output channel: out_valid/out_ready carry one result word with
// status and, on a successful receive, the dequeued descriptor.
// Every input word gives exactly one result word.
// The port table is a RAM read one slot per cycle, which sets the latency.
// The scan stops at the slot that holds the port, or after all bound ports when
// the port is not bound; a successful receive then reads the descriptor store
// before the result is shown. One word is processed at a time; the next word
// is taken the cycle after the result is accepted.
// Reset clears the bound count; the queue pointers of a slot are cleared when
// its port is bound, and the port table, queue pointers and descriptor store
// are never read before they are written.
// When the receiver stalls, the result stays on the outputs and no new input
// word is accepted.
`default_nettype none
module udp_port_demux_queue (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [1:0] op,
    input wire logic [15:0] port,
    input wire logic [15:0] ethertype,
    input wire logic [12:0] frame_len,
    input wire logic [15:0] udp_length,
    input wire logic [31:0] source_ip,
    input wire logic [15:0] source_port,
    input wire logic [12:0] max_len,
    output logic out_valid,
    input wire logic out_ready,
    output logic [2:0] status,
    output logic [31:0] out_source_ip,
    output logic [15:0] out_source_port,
    output logic [12:0] out_length
);
    import udpdmx_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    udpdmx_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat(stat),
        .ctrl(ctrl)
    );

    udpdmx_dp u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(ctrl),
        .stat(stat),
        .op(op),
        .port(port),
        .ethertype(ethertype),
        .frame_len(frame_len),
        .udp_length(udp_length),
        .source_ip(source_ip),
        .source_port(source_port),
        .max_len(max_len),
        .status(status),
        .out_source_ip(out_source_ip),
        .out_source_port(out_source_port),
        .out_length(out_length)
    );
endmodule
`default_nettype wire
